// File: rtl/touch_button_scanner_glow_defines.svh
// Assertion macros shared by the scanner RTL.
`ifndef TOUCH_BUTTON_SCANNER_GLOW_DEFINES_SVH
`define TOUCH_BUTTON_SCANNER_GLOW_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger.
`define TBSG_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scanner check failed in same cycle");

// Check that a condition holds in the cycle after its trigger.
`define TBSG_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scanner check failed one cycle later");

`endif

// File: rtl/tbsg_pkg.sv
package tbsg_pkg;

   localparam int BUTTONS    = 5;
   localparam int GLOW_CELLS = 4;
   localparam int GLOW_BITS  = 8;

   localparam int TOUCH_BITS    = 16;
   localparam int ELAPSED_BITS  = 16;
   localparam int HOLD_BITS     = 24;
   localparam int ACCUM_BITS    = 20;
   localparam int MAX_GLOW_BITS = 8;
   localparam int TIME_CFG_BITS = 16;
   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [TOUCH_BITS-1:0]    RESET_TOUCH_THRESHOLD = 16'd40;
   localparam logic [MAX_GLOW_BITS-1:0] RESET_MAX_GLOW        = 8'd255;
   localparam logic [TIME_CFG_BITS-1:0] RESET_ANIM_TRIGGER    = 16'd300;
   localparam logic [TIME_CFG_BITS-1:0] RESET_ANIM_STEP       = 16'd100;

   // Diffusion: (2*self + left + right) / 5, done as a reciprocal multiply
   localparam int DIFF_DIVISOR = 5;
   localparam int SUM_BITS     = GLOW_BITS + 2;
   localparam int RECIP_SHIFT  = SUM_BITS + 3;
   localparam int RECIP_MULT   = (1 << RECIP_SHIFT) / DIFF_DIVISOR + 1;
   localparam int PROD_BITS    = SUM_BITS + RECIP_SHIFT;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TOUCH_THRESHOLD = 2'd0,
      CSR_MAX_GLOW        = 2'd1,
      CSR_ANIM_TRIGGER    = 2'd2,
      CSR_ANIM_STEP       = 2'd3
   } csr_index_type;

   typedef logic [TOUCH_BITS-1:0]   touch_type;
   typedef logic [ELAPSED_BITS-1:0] elapsed_type;
   typedef logic [HOLD_BITS-1:0]    hold_type;
   typedef logic [GLOW_BITS-1:0]    glow_type;

   // Per-button status passed from the scanner to the glow engine
   typedef struct packed {
      logic [BUTTONS-1:0] pressed;
      logic [BUTTONS-1:0] fresh;
   } btn_status_type;

endpackage

// File: rtl/tbsg_buttons.sv
module tbsg_buttons (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  tbsg_pkg::touch_type        touch [tbsg_pkg::BUTTONS],
   input  tbsg_pkg::elapsed_type      elapsed,
   input  tbsg_pkg::touch_type        threshold,
   output tbsg_pkg::btn_status_type   status,
   output tbsg_pkg::hold_type         hold_next [tbsg_pkg::BUTTONS],
   output logic [tbsg_pkg::BUTTONS-1:0] edge_next
);

   tbsg_pkg::hold_type             hold_ff [tbsg_pkg::BUTTONS];
   tbsg_pkg::hold_type             hold_in [tbsg_pkg::BUTTONS];
   logic [tbsg_pkg::BUTTONS-1:0]   pressed_ff;
   logic [tbsg_pkg::BUTTONS-1:0]   pressed;
   logic [tbsg_pkg::BUTTONS-1:0]   fresh;

   // Compare each reading and advance its hold timer
   for (genvar i = 0; i < tbsg_pkg::BUTTONS; i++) begin : g_btn
      logic [tbsg_pkg::HOLD_BITS:0] hold_sum;

      assign pressed[i] = touch[i] < threshold;
      assign fresh[i]   = pressed[i] && (hold_ff[i] == '0);
      assign hold_sum   = {1'b0, hold_ff[i]} + (tbsg_pkg::HOLD_BITS + 1)'(elapsed);

      always_comb begin
         if (!pressed[i]) begin
            hold_in[i] = '0;
         end else if (hold_sum[tbsg_pkg::HOLD_BITS]) begin
            hold_in[i] = '1;
         end else begin
            hold_in[i] = hold_sum[tbsg_pkg::HOLD_BITS-1:0];
         end
      end

      assign hold_next[i] = hold_in[i];
   end

   assign status.pressed = pressed;
   assign status.fresh   = fresh;
   assign edge_next      = pressed & ~pressed_ff;

   // Hold timers and last pressed mask
   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff <= '0;
         for (int i = 0; i < tbsg_pkg::BUTTONS; i++) begin
            hold_ff[i] <= '0;
         end
      end else if (advance) begin
         pressed_ff <= pressed;
         for (int i = 0; i < tbsg_pkg::BUTTONS; i++) begin
            hold_ff[i] <= hold_in[i];
         end
      end
   end

endmodule

// File: rtl/tbsg_glow.sv
module tbsg_glow (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  tbsg_pkg::btn_status_type              status,
   input  tbsg_pkg::elapsed_type                 elapsed,
   input  logic [tbsg_pkg::MAX_GLOW_BITS-1:0]    max_glow,
   input  logic [tbsg_pkg::TIME_CFG_BITS-1:0]    trigger_ms,
   input  logic [tbsg_pkg::TIME_CFG_BITS-1:0]    step_ms,
   output tbsg_pkg::glow_type                    glow_next [tbsg_pkg::GLOW_CELLS],
   output logic                                  glow_valid_next
);

   tbsg_pkg::glow_type              glow_ff [tbsg_pkg::GLOW_CELLS];
   tbsg_pkg::glow_type              glow_in [tbsg_pkg::GLOW_CELLS];
   tbsg_pkg::glow_type              loaded  [tbsg_pkg::GLOW_CELLS];
   tbsg_pkg::glow_type              quot    [tbsg_pkg::GLOW_CELLS];
   logic [tbsg_pkg::GLOW_CELLS-1:0] nonzero;
   logic [tbsg_pkg::ACCUM_BITS-1:0] accum_ff;
   logic [tbsg_pkg::ACCUM_BITS-1:0] accum_in;
   logic [tbsg_pkg::ACCUM_BITS:0]   accum_sum;
   logic [tbsg_pkg::ACCUM_BITS-1:0] accum_sat;
   logic [tbsg_pkg::ACCUM_BITS-1:0] step_ext;
   logic                            run;
   tbsg_pkg::glow_type              glow_load;

   assign glow_load = tbsg_pkg::GLOW_BITS'(max_glow);

   // Saturating accumulator and diffusion trigger
   assign accum_sum = {1'b0, accum_ff} + (tbsg_pkg::ACCUM_BITS + 1)'(elapsed);
   assign accum_sat = accum_sum[tbsg_pkg::ACCUM_BITS] ? '1
                                                      : accum_sum[tbsg_pkg::ACCUM_BITS-1:0];
   assign step_ext  = tbsg_pkg::ACCUM_BITS'(step_ms);
   assign run       = accum_sat > tbsg_pkg::ACCUM_BITS'(trigger_ms);

   always_comb begin
      if (!run) begin
         accum_in = accum_sat;
      end else if (step_ext > accum_sat) begin
         accum_in = '0;
      end else begin
         accum_in = accum_sat - step_ext;
      end
   end

   // Load fresh presses, then diffuse each cell with its neighbors when the trigger runs
   for (genvar i = 0; i < tbsg_pkg::GLOW_CELLS; i++) begin : g_cell
      logic                              load;
      logic [tbsg_pkg::SUM_BITS-1:0]     left;
      logic [tbsg_pkg::SUM_BITS-1:0]     right;
      logic [tbsg_pkg::SUM_BITS-1:0]     wsum;
      logic [tbsg_pkg::PROD_BITS-1:0]    prod;

      if (i < tbsg_pkg::BUTTONS) begin : g_load
         assign load = status.fresh[i];
      end else begin : g_noload
         assign load = 1'b0;
      end

      assign loaded[i] = load ? glow_load : glow_ff[i];

      if (i == 0) begin : g_left_edge
         assign left = '0;
      end else begin : g_left
         assign left = tbsg_pkg::SUM_BITS'(loaded[i-1]);
      end

      if (i == tbsg_pkg::GLOW_CELLS - 1) begin : g_right_edge
         assign right = '0;
      end else begin : g_right
         assign right = tbsg_pkg::SUM_BITS'(loaded[i+1]);
      end

      assign wsum = {1'b0, loaded[i], 1'b0} + left + right;
      assign prod = tbsg_pkg::PROD_BITS'(wsum)
                    * tbsg_pkg::PROD_BITS'(tbsg_pkg::RECIP_MULT);
      assign quot[i]    = prod[tbsg_pkg::RECIP_SHIFT +: tbsg_pkg::GLOW_BITS];
      assign nonzero[i] = quot[i] != '0;
      assign glow_in[i] = run ? quot[i] : loaded[i];
      assign glow_next[i] = glow_in[i];
   end

   assign glow_valid_next = run && (nonzero != '0);

   // Glow cells and accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff <= '0;
         for (int i = 0; i < tbsg_pkg::GLOW_CELLS; i++) begin
            glow_ff[i] <= '0;
         end
      end else if (advance) begin
         accum_ff <= accum_in;
         for (int i = 0; i < tbsg_pkg::GLOW_CELLS; i++) begin
            glow_ff[i] <= glow_in[i];
         end
      end
   end

endmodule

// File: rtl/touch_button_scanner_glow.sv
// Touch button scanner with press glow.
// Request channel (req_valid/req_ready): five raw touch readings and the
// milliseconds since the previous scan. Response channel (rsp_valid/rsp_ready):
// pressed mask, rising-edge mask, five hold timers, four glow cells and a flag
// that a diffusion step ran with some cell left nonzero. One response per request.
// Configuration (csr_we/csr_index/csr_wdata): 0 touch threshold, 1 max glow,
// 2 animation trigger ms, 3 animation step ms; write only while idle.
// From request accept to response valid: one input register, then the compare,
// hold add, glow load and reciprocal-multiply diffusion run combinationally
// into the response register. Throughput is one request per cycle while responses
// are taken; the single diffusion multiplier per cell sets the critical path.
// A stalled response holds its register; the input register still takes one more
// request, after which req_ready drops until the response is taken.
// Reset clears both registers' valid flags, the hold timers, the glow cells, the
// accumulator and the pressed history, and loads the register defaults.
`include "touch_button_scanner_glow_defines.svh"

module touch_button_scanner_glow (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [tbsg_pkg::TOUCH_BITS-1:0]       req_touch_0,
   input  logic [tbsg_pkg::TOUCH_BITS-1:0]       req_touch_1,
   input  logic [tbsg_pkg::TOUCH_BITS-1:0]       req_touch_2,
   input  logic [tbsg_pkg::TOUCH_BITS-1:0]       req_touch_3,
   input  logic [tbsg_pkg::TOUCH_BITS-1:0]       req_touch_4,
   input  logic [tbsg_pkg::ELAPSED_BITS-1:0]     req_elapsed_ms,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [tbsg_pkg::BUTTONS-1:0]          rsp_press_mask,
   output logic [tbsg_pkg::BUTTONS-1:0]          rsp_edge_mask,
   output logic [tbsg_pkg::HOLD_BITS-1:0]        rsp_hold_0,
   output logic [tbsg_pkg::HOLD_BITS-1:0]        rsp_hold_1,
   output logic [tbsg_pkg::HOLD_BITS-1:0]        rsp_hold_2,
   output logic [tbsg_pkg::HOLD_BITS-1:0]        rsp_hold_3,
   output logic [tbsg_pkg::HOLD_BITS-1:0]        rsp_hold_4,
   output logic [tbsg_pkg::GLOW_BITS-1:0]        rsp_glow_a,
   output logic [tbsg_pkg::GLOW_BITS-1:0]        rsp_glow_b,
   output logic [tbsg_pkg::GLOW_BITS-1:0]        rsp_glow_c,
   output logic [tbsg_pkg::GLOW_BITS-1:0]        rsp_glow_d,
   output logic                                  rsp_glow_valid,
   input  logic                                  csr_we,
   input  logic [tbsg_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [tbsg_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   // Configuration registers
   tbsg_pkg::touch_type                       threshold_ff;
   logic [tbsg_pkg::MAX_GLOW_BITS-1:0]        max_glow_ff;
   logic [tbsg_pkg::TIME_CFG_BITS-1:0]        trigger_ff;
   logic [tbsg_pkg::TIME_CFG_BITS-1:0]        step_ff;

   // Input stage
   logic                                      in_vld_ff;
   tbsg_pkg::touch_type                       touch_ff [tbsg_pkg::BUTTONS];
   tbsg_pkg::elapsed_type                     elapsed_ff;

   // Response stage
   logic                                      rsp_vld_ff;
   logic [tbsg_pkg::BUTTONS-1:0]              press_ff;
   logic [tbsg_pkg::BUTTONS-1:0]              edge_ff;
   tbsg_pkg::hold_type                        hold_ff [tbsg_pkg::BUTTONS];
   tbsg_pkg::glow_type                        glow_ff [tbsg_pkg::GLOW_CELLS];
   logic                                      glow_valid_ff;

   logic                                      advance;
   logic                                      req_take;
   tbsg_pkg::btn_status_type                  status;
   tbsg_pkg::hold_type                        hold_in [tbsg_pkg::BUTTONS];
   logic [tbsg_pkg::BUTTONS-1:0]              edge_in;
   tbsg_pkg::glow_type                        glow_in [tbsg_pkg::GLOW_CELLS];
   logic                                      glow_valid_in;

   // Move the held request on when the response register is free or draining
   assign advance   = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign req_take  = req_valid && req_ready;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= tbsg_pkg::RESET_TOUCH_THRESHOLD;
         max_glow_ff  <= tbsg_pkg::RESET_MAX_GLOW;
         trigger_ff   <= tbsg_pkg::RESET_ANIM_TRIGGER;
         step_ff      <= tbsg_pkg::RESET_ANIM_STEP;
      end else if (csr_we) begin
         unique case (tbsg_pkg::csr_index_type'(csr_index))
            tbsg_pkg::CSR_TOUCH_THRESHOLD: begin
               threshold_ff <= csr_wdata;
            end
            tbsg_pkg::CSR_MAX_GLOW: begin
               max_glow_ff <= csr_wdata[tbsg_pkg::MAX_GLOW_BITS-1:0];
            end
            tbsg_pkg::CSR_ANIM_TRIGGER: begin
               trigger_ff <= csr_wdata;
            end
            tbsg_pkg::CSR_ANIM_STEP: begin
               step_ff <= csr_wdata;
            end
         endcase
      end
   end

   // Stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_vld_ff <= req_valid;
         end
         if (advance) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // Capture the request payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         touch_ff[0] <= req_touch_0;
         touch_ff[1] <= req_touch_1;
         touch_ff[2] <= req_touch_2;
         touch_ff[3] <= req_touch_3;
         touch_ff[4] <= req_touch_4;
         elapsed_ff  <= req_elapsed_ms;
      end
   end

   tbsg_buttons u_buttons (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .touch     (touch_ff),
      .elapsed   (elapsed_ff),
      .threshold (threshold_ff),
      .status    (status),
      .hold_next (hold_in),
      .edge_next (edge_in)
   );

   tbsg_glow u_glow (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .status          (status),
      .elapsed         (elapsed_ff),
      .max_glow        (max_glow_ff),
      .trigger_ms      (trigger_ff),
      .step_ms         (step_ff),
      .glow_next       (glow_in),
      .glow_valid_next (glow_valid_in)
   );

   // Capture the response payload
   always_ff @(posedge clock) begin
      if (advance) begin
         press_ff      <= status.pressed;
         edge_ff       <= edge_in;
         glow_valid_ff <= glow_valid_in;
         for (int i = 0; i < tbsg_pkg::BUTTONS; i++) begin
            hold_ff[i] <= hold_in[i];
         end
         for (int i = 0; i < tbsg_pkg::GLOW_CELLS; i++) begin
            glow_ff[i] <= glow_in[i];
         end
      end
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_press_mask = press_ff;
   assign rsp_edge_mask  = edge_ff;
   assign rsp_hold_0     = hold_ff[0];
   assign rsp_hold_1     = hold_ff[1];
   assign rsp_hold_2     = hold_ff[2];
   assign rsp_hold_3     = hold_ff[3];
   assign rsp_hold_4     = hold_ff[4];
   assign rsp_glow_a     = glow_ff[0];
   assign rsp_glow_b     = glow_ff[1];
   assign rsp_glow_c     = glow_ff[2];
   assign rsp_glow_d     = glow_ff[3];
   assign rsp_glow_valid = glow_valid_ff;

   // A rising edge is always a pressed button
   `TBSG_ASSERT_NOW(a_edge_in_press, rsp_vld_ff, (edge_ff & ~press_ff) == '0)
   // A released button 0 shows zero hold time
   `TBSG_ASSERT_NOW(a_hold_needs_press, rsp_vld_ff, (hold_ff[0] == '0) || press_ff[0])
   // The glow flag implies some lit cell
   `TBSG_ASSERT_NOW(a_glow_flag_lit, rsp_vld_ff && glow_valid_ff,
      (glow_ff[0] | glow_ff[1] | glow_ff[2] | glow_ff[3]) != '0)
   // A held request waits while the response is stalled
   `TBSG_ASSERT_NEXT(a_input_holds, in_vld_ff && rsp_vld_ff && !rsp_ready, in_vld_ff)

endmodule
